// File: rtl/core/dncd_pkg.sv
package dncd_pkg;

    localparam int DAY_BITS = 30;

    localparam int YEAR_W   = 22;
    localparam int ACC_W    = 24;
    localparam int OUT_W    = 40;
    localparam int IN_W     = 32;
    localparam int SHIFT    = 40;
    localparam int N_STAGES = 10;

    localparam logic [DAY_BITS-1:0] BC_DAYS       = DAY_BITS'(1721424);
    localparam logic [DAY_BITS-1:0] JULIAN_AD_END = DAY_BITS'(577737);
    localparam logic [ACC_W-1:0]    YEAR_MAX      = ACC_W'(4194303);
    localparam logic [ACC_W-1:0]    BC_FIRST_YEAR = ACC_W'(4713);

    localparam logic [17:0] CYCLE400 = 18'd146097;
    localparam logic [15:0] CYCLE100 = 16'd36524;
    localparam logic [10:0] CYCLE4   = 11'd1461;

    // Reciprocals scaled by 2^SHIFT, rounded down; the estimate they give is
    // low by at most one, and a single correction step fixes it.
    localparam logic [63:0] RECIP400_W = (64'd1 << SHIFT) / 64'd146097;
    localparam logic [63:0] RECIP4_W   = (64'd1 << SHIFT) / 64'd1461;
    localparam logic [29:0] RECIP400   = RECIP400_W[29:0];
    localparam logic [29:0] RECIP4     = RECIP4_W[29:0];

    // First day index of each month within a common year.
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] s;
        case (idx)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/core/day_number_to_calendar_date.sv
// Channel   Direction  Word fields (lowest bit up)
// s_axis    in         day_count[29:0], zero fill to 32 bits
// m_axis    out        day_of_month[4:0], month_number[8:5], year_number[30:9],
//                      before_christ[31], out_of_range[32], zero fill to 40 bits
//
// A word passes through ten register stages. A new word can be taken in every cycle
// while the output word is not held.
// The two reciprocal multipliers (by 146097 or 1461, then by 1461) set the stage depth.
// All stages advance together; when the output word is held, the whole
// pipeline holds and s_axis_tready falls, so nothing is dropped or repeated.
// rst_n clears the valid bits only.
module day_number_to_calendar_date
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // day_count[29:0], zero fill
    input  logic [dncd_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // day_of_month, month_number, year_number, before_christ, out_of_range
    output logic [dncd_pkg::OUT_W-1:0] m_axis_tdata
);
    import dncd_pkg::*;

    logic                    adv;
    logic [N_STAGES-1:0]     valid_reg;
    logic [N_STAGES-1:0]     valid_next;

    logic [DAY_BITS-1:0]     x1_reg, x1_next, x2_reg;
    logic                    bc_reg [1:9];
    logic                    gr_reg [1:9];
    logic                    bc1_next, gr1_next;
    logic [59:0]             prod2_reg, prod2_next;
    logic [13:0]             q3_reg, q3_next, q4;
    logic [18:0]             r3_reg, r3_next;
    logic [17:0]             r4_reg, r4_next;
    logic [ACC_W-1:0]        acc4_reg, acc4_next, acc5_reg, acc5_next, acc6_reg, acc7_reg;
    logic [ACC_W-1:0]        acc8_reg, acc8_next;
    logic [1:0]              k100_reg [5:9];
    logic [1:0]              k100_next;
    logic [15:0]             r5_reg, r5_next, r6_keep_reg;
    logic [45:0]             prod6_reg, prod6_next;
    logic [4:0]              q7_reg, q7_next, q8_reg, q8_next;
    logic [11:0]             r7_reg, r7_next;
    logic [10:0]             r8_reg, r8_next;
    logic [8:0]              r9_reg, r9_next;
    logic [ACC_W-1:0]        year9_reg, year9_next;
    logic                    leap9_reg, leap9_next;
    logic [OUT_W-1:0]        out_reg, out_next;

    assign adv           = !valid_reg[N_STAGES-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = valid_reg[N_STAGES-1];
    assign m_axis_tdata  = out_reg;
    assign valid_next    = {valid_reg[N_STAGES-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: pick the calendar and the offset into it.
    always_comb
    begin
        logic [DAY_BITS-1:0] d;
        logic [DAY_BITS-1:0] a;
        d        = s_axis_tdata[DAY_BITS-1:0];
        a        = d - BC_DAYS;
        bc1_next = d < BC_DAYS;
        gr1_next = !bc1_next && (a >= JULIAN_AD_END);
        if (bc1_next)
        begin
            x1_next = d;
        end
        else if (gr1_next)
        begin
            x1_next = a - DAY_BITS'(2);
        end
        else
        begin
            x1_next = a;
        end
    end

    // Stage 2: reciprocal multiply, by 400-year or 4-year cycle length.
    assign prod2_next = 60'(x1_reg) * 60'(gr_reg[1] ? RECIP400 : RECIP4);

    // Stage 3: quotient estimate and its remainder.
    always_comb
    begin
        logic [31:0] qd;
        q3_next = prod2_reg[SHIFT+13:SHIFT];
        qd      = gr_reg[2] ? 32'(q3_next) * 32'(CYCLE400) : 32'(q3_next) * 32'(CYCLE4);
        r3_next = 19'(32'(x2_reg) - qd);
    end

    // Stage 4: correct the estimate by one where needed.
    always_comb
    begin
        logic [18:0] dv;
        dv = gr_reg[3] ? 19'(CYCLE400) : 19'(CYCLE4);
        if (r3_reg >= dv)
        begin
            q4      = q3_reg + 14'd1;
            r4_next = 18'(r3_reg - dv);
        end
        else
        begin
            q4      = q3_reg;
            r4_next = r3_reg[17:0];
        end
        acc4_next = gr_reg[3] ? ACC_W'(q4) * ACC_W'(400) : ACC_W'(q4) << 2;
    end

    // Stage 5: centuries within the 400-year cycle; the last century is
    // one day longer, so the count is clamped at three.
    always_comb
    begin
        k100_next = 2'd0;
        if (gr_reg[4])
        begin
            if (r4_reg >= 18'd109572)
            begin
                k100_next = 2'd3;
            end
            else if (r4_reg >= 18'd73048)
            begin
                k100_next = 2'd2;
            end
            else if (r4_reg >= 18'(CYCLE100))
            begin
                k100_next = 2'd1;
            end
        end
        r5_next   = 16'(r4_reg - 18'(k100_next) * 18'(CYCLE100));
        acc5_next = acc4_reg + ACC_W'(k100_next) * ACC_W'(100);
    end

    // Stage 6: reciprocal multiply by the 4-year cycle length.
    assign prod6_next = 46'(r5_reg) * 46'(RECIP4);

    // Stage 7: estimate of the 4-year groups.
    always_comb
    begin
        q7_next = prod6_reg[SHIFT+4:SHIFT];
        r7_next = 12'(r6_keep_reg - 16'(q7_next) * 16'(CYCLE4));
    end

    // Stage 8: correction.
    always_comb
    begin
        if (r7_reg >= 12'(CYCLE4))
        begin
            q8_next = q7_reg + 5'd1;
            r8_next = 11'(r7_reg - 12'(CYCLE4));
        end
        else
        begin
            q8_next = q7_reg;
            r8_next = r7_reg[10:0];
        end
        acc8_next = acc7_reg + (ACC_W'(q8_next) << 2);
    end

    // Stage 9: year within the group. BC groups open with the leap year,
    // AD groups close with it.
    always_comb
    begin
        logic [1:0]  k;
        logic [10:0] sub;
        logic [ACC_W-1:0] acc;
        if (bc_reg[8])
        begin
            k = (r8_reg < 11'd366) ? 2'd0 : (r8_reg < 11'd731) ? 2'd1 :
                (r8_reg < 11'd1096) ? 2'd2 : 2'd3;
        end
        else
        begin
            k = (r8_reg < 11'd365) ? 2'd0 : (r8_reg < 11'd730) ? 2'd1 :
                (r8_reg < 11'd1095) ? 2'd2 : 2'd3;
        end
        sub = 11'(k) * 11'd365 + 11'(bc_reg[8] && (k != 2'd0));
        r9_next = 9'(r8_reg - sub);
        acc = acc8_reg + ACC_W'(k);
        year9_next = bc_reg[8] ? BC_FIRST_YEAR - acc : acc + ACC_W'(1);
        // In the Gregorian calendar a century year is leap only as the last one of the 400-year cycle.
        if (bc_reg[8])
        begin
            leap9_next = (k == 2'd0);
        end
        else
        begin
            leap9_next = (k == 2'd3) && (!gr_reg[8] || (q8_reg != 5'd24) ||
                                         (k100_reg[8] == 2'd3));
        end
    end

    // Stage 10: month and day, range check.
    always_comb
    begin
        logic [3:0] mon;
        logic [8:0] base;
        logic [8:0] st;
        logic [4:0] day;
        mon  = 4'd1;
        base = 9'd0;
        for (int i = 1; i < 12; i++)
        begin
            st = month_start(4'(i)) + 9'(leap9_reg && (i >= 2));
            if (r9_reg >= st)
            begin
                mon  = 4'(i + 1);
                base = st;
            end
        end
        day = 5'(r9_reg - base + 9'd1);
        if (year9_reg > YEAR_MAX)
        begin
            out_next = OUT_W'(1) << 32;
        end
        else
        begin
            out_next = OUT_W'({1'b0, bc_reg[9], year9_reg[YEAR_W-1:0], mon, day});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg      <= x1_next;
            bc_reg[1]   <= bc1_next;
            gr_reg[1]   <= gr1_next;
            for (int s = 2; s <= 9; s++)
            begin
                bc_reg[s] <= bc_reg[s-1];
                gr_reg[s] <= gr_reg[s-1];
            end
            x2_reg      <= x1_reg;
            prod2_reg   <= prod2_next;
            q3_reg      <= q3_next;
            r3_reg      <= r3_next;
            r4_reg      <= r4_next;
            acc4_reg    <= acc4_next;
            k100_reg[5] <= k100_next;
            for (int s = 6; s <= 9; s++)
            begin
                k100_reg[s] <= k100_reg[s-1];
            end
            r5_reg      <= r5_next;
            acc5_reg    <= acc5_next;
            prod6_reg   <= prod6_next;
            r6_keep_reg <= r5_reg;
            acc6_reg    <= acc5_reg;
            q7_reg      <= q7_next;
            r7_reg      <= r7_next;
            acc7_reg    <= acc6_reg;
            q8_reg      <= q8_next;
            r8_reg      <= r8_next;
            acc8_reg    <= acc8_next;
            r9_reg      <= r9_next;
            year9_reg   <= year9_next;
            leap9_reg   <= leap9_next;
            out_reg     <= out_next;
        end
    end

endmodule

// File: rtl/core/dncd_checker.sv
module dncd_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [dncd_pkg::IN_W-1:0]  s_axis_tdata,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [dncd_pkg::OUT_W-1:0] m_axis_tdata
);
    import dncd_pkg::*;

    // A held output word stays valid.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // A held output word keeps its value.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // The input side is stalled only by a held output word.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input stalled without cause");

    // An out-of-range word carries no date.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("out-of-range word carries a date");

    // A converted date has a real month and day and a nonzero year.
    a_date: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[32] |->
        m_axis_tdata[4:0] != 5'd0 && m_axis_tdata[8:5] != 4'd0 &&
        m_axis_tdata[8:5] <= 4'd12 && m_axis_tdata[30:9] != 22'd0)
        else $error("converted date out of its field ranges");

endmodule

bind day_number_to_calendar_date dncd_checker u_dncd_checker (.*);
